>>> design/assert_macros.svh
// Assertion macros shared by the design files.
// Each macro expands to one labeled concurrent assertion on a clock and active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PDF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Expression must never be true outside reset.
`define PDF_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  `PDF_ASSERT(label, clk, rst_n, !(expr), msg)

`endif

>>> design/pdf_pkg.sv
// Shared constants and types of the Pareto dominance fitness unit.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package pdf_pkg;

  localparam int unsigned MAX_SAMPLES_DEF = 64;
  localparam int unsigned OBJECTIVES_DEF  = 4;

  localparam int unsigned OBJ_W     = 32;
  localparam int unsigned RANK_W    = 7;
  localparam int unsigned SIDX_W    = 6;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned OBJ_PORTS = 4;

  localparam int unsigned MASK_W  = 4;
  localparam int unsigned APB_W   = 32;
  localparam int unsigned ADDR_W  = 3;

  localparam int unsigned REG_MODE = 0;
  localparam int unsigned REG_MASK = 1;

  localparam logic       MODE_RESET = 1'b1;
  localparam logic [3:0] MASK_RESET = 4'hF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_en;      // store the incoming sample
    logic cmp_clear;  // clear the dominance count
    logic cmp_en;     // compare data on the two read ports
    logic div_load;   // load the divider with the count
    logic div_step;   // one quotient bit
    logic emit;       // register one result
    logic last;       // the result is the last of the set
  } pdf_cmd_t;

endpackage

>>> design/pareto_dominance_fitness_unit.sv
// Loading takes one sample per cycle while the unit is not busy. After the final sample, each result
// comes from a compare sweep over all stored samples through the second memory read port and then a
// divider in dominance mode, and from the stored sample alone in single mode; results come in load
// order with no stall. The unit is busy from the final sample until the last result is registered.
// Reset clears the controller and sets mode to dominance and all objectives selected;
// the sample memory is not cleared.
`timescale 1ns / 1ps

module pareto_dominance_fitness_unit #(
  parameter int unsigned MAX_SAMPLES = pdf_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned OBJECTIVES  = pdf_pkg::OBJECTIVES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pdf_pkg::ADDR_W-1:0]        paddr,
  input  logic [pdf_pkg::APB_W-1:0]         pwdata,
  output logic [pdf_pkg::APB_W-1:0]         prdata,
  output logic                              pready,
  input  logic                              start,
  output logic                              busy,
  input  logic [pdf_pkg::RANK_W-1:0]        pareto_rank_i,
  input  logic signed [pdf_pkg::OBJ_W-1:0]  objective_0_i,
  input  logic signed [pdf_pkg::OBJ_W-1:0]  objective_1_i,
  input  logic signed [pdf_pkg::OBJ_W-1:0]  objective_2_i,
  input  logic signed [pdf_pkg::OBJ_W-1:0]  objective_3_i,
  input  logic                              final_sample_i,
  output logic                              result_strobe_o,
  output logic [pdf_pkg::SIDX_W-1:0]        sample_index_o,
  output logic signed [pdf_pkg::OBJ_W-1:0]  fitness_o,
  output logic                              last_result_o
);

  localparam int unsigned IDX_W = $clog2(MAX_SAMPLES);
  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);

  logic                       mode;
  logic [pdf_pkg::MASK_W-1:0] mask;
  pdf_pkg::pdf_cmd_t          cmd;
  logic [IDX_W-1:0]           wr_addr;
  logic [IDX_W-1:0]           addr_a;
  logic [IDX_W-1:0]           addr_b;
  logic [CNT_W-1:0]           count;

  pdf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mode_o  (mode),
    .mask_o  (mask)
  );

  pdf_ctrl #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_o         (busy),
    .final_sample_i (final_sample_i),
    .mode_i         (mode),
    .cmd_o          (cmd),
    .wr_addr_o      (wr_addr),
    .addr_a_o       (addr_a),
    .addr_b_o       (addr_b),
    .count_o        (count)
  );

  pdf_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .OBJECTIVES  (OBJECTIVES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .wr_addr_i      (wr_addr),
    .addr_a_i       (addr_a),
    .addr_b_i       (addr_b),
    .count_i        (count),
    .mode_i         (mode),
    .mask_i         (mask),
    .pareto_rank_i  (pareto_rank_i),
    .objective_0_i  (objective_0_i),
    .objective_1_i  (objective_1_i),
    .objective_2_i  (objective_2_i),
    .objective_3_i  (objective_3_i),
    .strobe_o       (result_strobe_o),
    .sample_index_o (sample_index_o),
    .fitness_o      (fitness_o),
    .last_result_o  (last_result_o)
  );

endmodule

>>> design/pdf_regs.sv
// Configuration registers behind an APB-style port.
// Depends on pdf_pkg for register indexes, widths and reset values.
`timescale 1ns / 1ps

module pdf_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pdf_pkg::ADDR_W-1:0]  paddr,
  input  logic [pdf_pkg::APB_W-1:0]   pwdata,
  output logic [pdf_pkg::APB_W-1:0]   prdata,
  output logic                        pready,
  output logic                        mode_o,
  output logic [pdf_pkg::MASK_W-1:0]  mask_o
);

  logic                       mode_q;
  logic [pdf_pkg::MASK_W-1:0] mask_q;
  logic                       reg_idx;
  logic                       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= pdf_pkg::MODE_RESET;
      mask_q <= pdf_pkg::MASK_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        1'(pdf_pkg::REG_MODE): mode_q <= pwdata[0];
        1'(pdf_pkg::REG_MASK): mask_q <= pwdata[pdf_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      1'(pdf_pkg::REG_MODE): prdata = pdf_pkg::APB_W'(mode_q);
      1'(pdf_pkg::REG_MASK): prdata = pdf_pkg::APB_W'(mask_q);
      default:               prdata = '0;
    endcase
  end

  assign mode_o = mode_q;
  assign mask_o = mask_q;

endmodule

>>> design/pdf_ctrl.sv
// Controller state machine: sample loading, per-sample compare sweep and divide (dominance mode), and emit.
// Depends on pdf_pkg for the command struct and assert_macros.svh for checks.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pdf_ctrl #(
  parameter int unsigned MAX_SAMPLES = pdf_pkg::MAX_SAMPLES_DEF,
  localparam int unsigned IDX_W  = $clog2(MAX_SAMPLES),
  localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              final_sample_i,
  input  logic              mode_i,
  output pdf_pkg::pdf_cmd_t cmd_o,
  output logic [IDX_W-1:0]  wr_addr_o,
  output logic [IDX_W-1:0]  addr_a_o,
  output logic [IDX_W-1:0]  addr_b_o,
  output logic [CNT_W-1:0]  count_o
);

  localparam int unsigned STEP_W = $clog2(pdf_pkg::FRAC_BITS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_DLOAD = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  s_q, s_d;
  logic [CNT_W-1:0]  k_q, k_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              last_sample;

  assign last_sample = (CNT_W'(CNT_W'(s_q) + CNT_W'(1)) == count_q);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    s_d     = s_q;
    k_d     = k_q;
    step_d  = step_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.wr_en = 1'b1;
          count_d     = CNT_W'(count_q + CNT_W'(1));
          // A sample that fills the store closes the set as well.
          if (final_sample_i || (count_q == CNT_W'(MAX_SAMPLES - 1))) begin
            s_d     = '0;
            state_d = S_PREP;
          end
        end
      end
      S_PREP: begin
        k_d             = '0;
        cmd_o.cmp_clear = 1'b1;
        state_d         = mode_i ? S_CMP : S_EMIT;
      end
      S_CMP: begin
        // Read data comes in the cycle after its address, so k runs up to count and compares start at k = 1.
        cmd_o.cmp_en = (k_q != '0);
        k_d          = CNT_W'(k_q + CNT_W'(1));
        if (k_q == count_q) begin
          state_d = S_DLOAD;
        end
      end
      S_DLOAD: begin
        cmd_o.div_load = 1'b1;
        step_d         = '0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = STEP_W'(step_q + STEP_W'(1));
        if (step_q == STEP_W'(pdf_pkg::FRAC_BITS - 1)) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        cmd_o.last = last_sample;
        if (last_sample) begin
          count_d = '0;
          state_d = S_IDLE;
        end else begin
          s_d     = IDX_W'(s_q + IDX_W'(1));
          state_d = S_PREP;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      s_q     <= '0;
      k_q     <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      s_q     <= s_d;
      k_q     <= k_d;
      step_q  <= step_d;
    end
  end

  assign wr_addr_o = count_q[IDX_W-1:0];
  assign addr_a_o  = s_q;
  assign addr_b_o  = k_q[IDX_W-1:0];
  assign count_o   = count_q;

  `PDF_ASSERT(a_sweep_bound, clk_i, rst_ni, (state_q == S_CMP) |-> (k_q <= count_q), "compare sweep ran past the set")
  `PDF_ASSERT(a_last_to_idle, clk_i, rst_ni, (cmd_o.emit && cmd_o.last) |=> (state_q == S_IDLE), "last result did not return to idle")
  `PDF_ASSERT_NEVER(a_eval_nonempty, clk_i, rst_ni, (state_q != S_IDLE) && (count_q == '0), "evaluation with an empty set")

endmodule

>>> design/pdf_datapath.sv
// Datapath: sample memory, dominance compare, dominance counter, divider and result registers.
// Depends on pdf_pkg for widths and the command struct, assert_macros.svh for checks.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pdf_datapath #(
  parameter int unsigned MAX_SAMPLES = pdf_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned OBJECTIVES  = pdf_pkg::OBJECTIVES_DEF,
  localparam int unsigned IDX_W = $clog2(MAX_SAMPLES),
  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pdf_pkg::pdf_cmd_t            cmd_i,
  input  logic [IDX_W-1:0]             wr_addr_i,
  input  logic [IDX_W-1:0]             addr_a_i,
  input  logic [IDX_W-1:0]             addr_b_i,
  input  logic [CNT_W-1:0]             count_i,
  input  logic                         mode_i,
  input  logic [pdf_pkg::MASK_W-1:0]   mask_i,
  input  logic [pdf_pkg::RANK_W-1:0]   pareto_rank_i,
  input  logic signed [pdf_pkg::OBJ_W-1:0] objective_0_i,
  input  logic signed [pdf_pkg::OBJ_W-1:0] objective_1_i,
  input  logic signed [pdf_pkg::OBJ_W-1:0] objective_2_i,
  input  logic signed [pdf_pkg::OBJ_W-1:0] objective_3_i,
  output logic                         strobe_o,
  output logic [pdf_pkg::SIDX_W-1:0]   sample_index_o,
  output logic signed [pdf_pkg::OBJ_W-1:0] fitness_o,
  output logic                         last_result_o
);

  localparam int unsigned OW    = pdf_pkg::OBJ_W;
  localparam int unsigned RW    = pdf_pkg::RANK_W;
  localparam int unsigned ROW_W = RW + OBJECTIVES * OW;
  localparam int unsigned DIV_W = $clog2(MAX_SAMPLES + 2);
  localparam int unsigned FB    = pdf_pkg::FRAC_BITS;

  logic [OW-1:0]    obj_in [pdf_pkg::OBJ_PORTS];
  logic [ROW_W-1:0] wr_row;
  logic [ROW_W-1:0] mem_q [MAX_SAMPLES];
  logic [ROW_W-1:0] rd_a_q, rd_b_q;

  logic [CNT_W-1:0] wins_q;
  logic [DIV_W-1:0] rem_q;
  logic [FB-1:0]    quo_q;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   divisor;

  logic [OBJECTIVES-1:0] lt_vec;
  logic [OBJECTIVES-1:0] sel;
  logic                  beats;
  logic [RW-1:0]         rank_m1;
  logic [OW-1:0]         single_fit;
  logic [OW-1:0]         fit;

  logic                  strobe_q;
  logic [IDX_W-1:0]      sidx_q;
  logic [OW-1:0]         fit_q;
  logic                  last_q;

  assign obj_in[0] = objective_0_i;
  assign obj_in[1] = objective_1_i;
  assign obj_in[2] = objective_2_i;
  assign obj_in[3] = objective_3_i;

  // Row layout: rank in the low bits, then one word per objective.
  always_comb begin
    wr_row         = '0;
    wr_row[RW-1:0] = pareto_rank_i;
    for (int o = 0; o < OBJECTIVES; o++) begin
      wr_row[RW + o*OW +: OW] = obj_in[o];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_row;
    end
    rd_a_q <= mem_q[addr_a_i];
    rd_b_q <= mem_q[addr_b_i];
  end

  // Sample A beats sample B when it is strictly smaller on every selected objective.
  assign sel = mask_i[OBJECTIVES-1:0];
  always_comb begin
    for (int o = 0; o < OBJECTIVES; o++) begin
      lt_vec[o] = $signed(rd_a_q[RW + o*OW +: OW]) < $signed(rd_b_q[RW + o*OW +: OW]);
    end
  end
  assign beats = &(~sel | lt_vec);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wins_q <= '0;
    end else if (cmd_i.cmp_clear) begin
      wins_q <= '0;
    end else if (cmd_i.cmp_en && beats) begin
      wins_q <= CNT_W'(wins_q + CNT_W'(1));
    end
  end

  // Restoring divider for wins * 2^16 / (count + 1), one quotient bit per cycle.
  // The count never exceeds the divisor, so the remainder starts at the count.
  assign divisor = (DIV_W+1)'((DIV_W+1)'(count_i) + (DIV_W+1)'(1));
  assign trial   = {rem_q, 1'b0};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      rem_q <= DIV_W'(wins_q);
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (trial >= divisor) begin
        rem_q <= DIV_W'(trial - divisor);
        quo_q <= {quo_q[FB-2:0], 1'b1};
      end else begin
        rem_q <= DIV_W'(trial);
        quo_q <= {quo_q[FB-2:0], 1'b0};
      end
    end
  end

  // Rank zero counts as rank one.
  assign rank_m1 = (rd_a_q[RW-1:0] == '0) ? '0 : RW'(rd_a_q[RW-1:0] - RW'(1));

  always_comb begin
    logic found;
    found      = 1'b0;
    single_fit = '0;
    for (int o = 0; o < OBJECTIVES; o++) begin
      if (sel[o] && !found) begin
        single_fit = rd_a_q[RW + o*OW +: OW];
        found      = 1'b1;
      end
    end
  end

  assign fit = mode_i ? OW'({rank_m1, quo_q}) : single_fit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      sidx_q <= addr_a_i;
      fit_q  <= fit;
      last_q <= cmd_i.last;
    end
  end

  assign strobe_o       = strobe_q;
  assign sample_index_o = pdf_pkg::SIDX_W'(sidx_q);
  assign fitness_o      = fit_q;
  assign last_result_o  = last_q;

  `PDF_ASSERT(a_wins_bound, clk_i, rst_ni, cmd_i.div_load |-> (wins_q <= count_i), "dominance count exceeds set size")

endmodule

>>> test/tb_pareto_dominance_fitness_unit.sv
// Self-checking testbench for pareto_dominance_fitness_unit: directed and random sample sets
// under several mode and mask settings, with results checked against a built-in predictor.
// Depends on pdf_pkg and the unit's top module only.
`timescale 1ns / 1ps

module tb_pareto_dominance_fitness_unit;
  import pdf_pkg::*;

  localparam int unsigned N_SLOTS       = MAX_SAMPLES_DEF;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned RAND_PHASES   = 8;
  localparam int unsigned PHASE_ITEMS   = 36;

  typedef struct packed {
    logic [RANK_W-1:0]                rank;
    logic [OBJ_PORTS-1:0][OBJ_W-1:0] obj;
    logic                             is_last;
  } sample_t;

  typedef struct packed {
    logic [SIDX_W-1:0] index;
    logic [OBJ_W-1:0]  value;
    logic              last;
  } fitness_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [APB_W-1:0]  pwdata  = '0;
  logic [APB_W-1:0]  prdata;
  logic              pready;

  logic                    start           = 1'b0;
  logic                    busy;
  logic [RANK_W-1:0]       pareto_rank_i   = '0;
  logic signed [OBJ_W-1:0] objective_0_i   = '0;
  logic signed [OBJ_W-1:0] objective_1_i   = '0;
  logic signed [OBJ_W-1:0] objective_2_i   = '0;
  logic signed [OBJ_W-1:0] objective_3_i   = '0;
  logic                    final_sample_i  = 1'b0;
  logic                    result_strobe_o;
  logic [SIDX_W-1:0]       sample_index_o;
  logic signed [OBJ_W-1:0] fitness_o;
  logic                    last_result_o;

  pareto_dominance_fitness_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .start          (start),
    .busy           (busy),
    .pareto_rank_i  (pareto_rank_i),
    .objective_0_i  (objective_0_i),
    .objective_1_i  (objective_1_i),
    .objective_2_i  (objective_2_i),
    .objective_3_i  (objective_3_i),
    .final_sample_i (final_sample_i),
    .result_strobe_o(result_strobe_o),
    .sample_index_o (sample_index_o),
    .fitness_o      (fitness_o),
    .last_result_o  (last_result_o)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: a mirror of the sample memory and the two registers.
  logic [OBJ_W-1:0]  obj_mem  [N_SLOTS][OBJ_PORTS];
  logic [RANK_W-1:0] rank_mem [N_SLOTS];
  int unsigned       loaded_cnt = 0;
  logic              mode_cfg   = MODE_RESET;
  logic [MASK_W-1:0] mask_cfg   = MASK_RESET;

  sample_t     sample_q[$];
  fitness_t    fitness_expect_q[$];
  sample_t     cur_sample = '0;
  int unsigned gap_left   = 0;
  bit          no_idle    = 1'b0;
  int unsigned err_cnt    = 0;

  // Stores one accepted sample and, when the set closes, queues the fitness of every sample.
  function automatic void rank_and_store(sample_t smp);
    int unsigned slot, count, wins, rk;
    bit          beats;
    logic [OBJ_W-1:0] fit;
    fitness_t    res;
    slot = (loaded_cnt >= N_SLOTS) ? N_SLOTS - 1 : loaded_cnt;
    rank_mem[slot] = smp.rank;
    for (int o = 0; o < OBJ_PORTS; o++) obj_mem[slot][o] = smp.obj[o];
    count = slot + 1;
    loaded_cnt = count;
    // A sample that fills the last place closes the set even without its final bit.
    if (!smp.is_last && count < N_SLOTS) return;
    for (int s = 0; s < count; s++) begin
      if (mode_cfg) begin
        wins = 0;
        for (int k = 0; k < count; k++) begin
          beats = 1'b1;
          for (int o = 0; o < OBJ_PORTS; o++) begin
            if (mask_cfg[o] && !($signed(obj_mem[s][o]) < $signed(obj_mem[k][o]))) beats = 1'b0;
          end
          if (beats) wins++;
        end
        rk = rank_mem[s];
        if (rk == 0) rk = 1;
        fit = ((rk - 1) << FRAC_BITS) + ((wins << FRAC_BITS) / (count + 1));
      end else begin
        // The lowest numbered selected objective wins; none selected gives zero.
        fit = '0;
        for (int o = OBJ_PORTS - 1; o >= 0; o--) begin
          if (mask_cfg[o]) fit = obj_mem[s][o];
        end
      end
      res.index = SIDX_W'(s);
      res.value = fit;
      res.last  = (s + 1 == count);
      fitness_expect_q.push_back(res);
    end
    loaded_cnt = 0;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if ($urandom_range(0, 99) < 3) no_idle = !no_idle;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver: presents queued samples and advances on every accepted transfer.
  always @(posedge clk_i) begin
    sample_t nxt;
    bit      free;
    if (!rst_ni) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else begin
      free = !start;
      if (start && !busy) begin
        rank_and_store(cur_sample);
        free = 1'b1;
      end
      if (free) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          start    <= 1'b0;
        end else if (sample_q.size() != 0) begin
          nxt = sample_q.pop_front();
          cur_sample     <= nxt;
          pareto_rank_i  <= nxt.rank;
          objective_0_i  <= nxt.obj[0];
          objective_1_i  <= nxt.obj[1];
          objective_2_i  <= nxt.obj[2];
          objective_3_i  <= nxt.obj[3];
          final_sample_i <= nxt.is_last;
          start          <= 1'b1;
          gap_left       <= pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result must match the oldest expected fitness.
  always @(posedge clk_i) begin
    fitness_t want;
    if (rst_ni && result_strobe_o) begin
      if (fitness_expect_q.size() == 0) begin
        $error("unexpected result: sample_index %0d fitness %h", sample_index_o, fitness_o);
        err_cnt++;
      end else begin
        want = fitness_expect_q.pop_front();
        if (sample_index_o !== want.index) begin
          $error("sample_index: expected %0d, actual %0d", want.index, sample_index_o);
          err_cnt++;
        end
        if (fitness_o !== want.value) begin
          $error("fitness: expected %h, actual %h", want.value, fitness_o);
          err_cnt++;
        end
        if (last_result_o !== want.last) begin
          $error("last_result: expected %0b, actual %0b", want.last, last_result_o);
          err_cnt++;
        end
      end
    end
  end

  // Writes one register over APB, then reads it back.
  task automatic set_register(input int unsigned idx, input logic [APB_W-1:0] value);
    logic [APB_W-1:0] keep;
    keep = (idx == REG_MODE) ? APB_W'(1) : APB_W'(4'hF);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx * 4);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_MODE) mode_cfg = value[0];
    else mask_cfg = value[MASK_W-1:0];
    @(posedge clk_i);
    psel    <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if ((prdata & keep) !== (value & keep)) begin
      $error("prdata: expected %h, actual %h", value & keep, prdata & keep);
      err_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Waits until every queued sample is taken and every expected fitness has arrived.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (sample_q.size() != 0 || start || busy || fitness_expect_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic void push_sample(input logic [RANK_W-1:0] rank, input logic [OBJ_W-1:0] o0,
                                      input logic [OBJ_W-1:0] o1, input logic [OBJ_W-1:0] o2,
                                      input logic [OBJ_W-1:0] o3, input logic fin);
    sample_t smp;
    smp.rank    = rank;
    smp.obj     = {o3, o2, o1, o0};
    smp.is_last = fin;
    sample_q.push_back(smp);
  endfunction

  // Small values give frequent ties and dominance; the rest cover every bit and the extremes.
  function automatic logic [OBJ_W-1:0] rand_objective();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        v = int'($urandom_range(0, 4)) - 2;
        return $urandom_range(0, 1) ? OBJ_W'(v * 65536) : OBJ_W'(v);
      end
      4: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return OBJ_W'($urandom());
    endcase
  endfunction

  function automatic void push_random_set(input int unsigned len, input bit close_set);
    logic [RANK_W-1:0] rk;
    for (int i = 0; i < len; i++) begin
      rk = ($urandom_range(0, 9) == 0) ? RANK_W'($urandom_range(0, 127))
                                       : RANK_W'($urandom_range(1, 64));
      push_sample(rk, rand_objective(), rand_objective(), rand_objective(), rand_objective(),
                  (i == len - 1) ? close_set : 1'b0);
    end
  endfunction

  initial begin
    int unsigned n, len, r;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: dominance mode, all objectives. Rank zero alone in a set.
    push_sample(7'd0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
    // Extremes of rank and objectives.
    push_sample(7'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    push_sample(7'd64, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    push_sample(7'd127, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    push_sample(7'd65, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    // Ties and a sample better on only one objective never count as a win.
    push_sample(7'd2, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
    push_sample(7'd3, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
    push_sample(7'd1, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b1);
    wait_idle();

    // Single mode with nothing selected gives zero.
    set_register(REG_MODE, 0);
    set_register(REG_MASK, 0);
    push_sample(7'd5, 32'h1234_5678, 32'hDEAD_BEEF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    push_sample(7'd9, 32'hFFFF_FFFF, 32'h0, 32'h5555_AAAA, 32'hAAAA_5555, 1'b1);
    // Two samples are left loaded while the mode changes.
    push_sample(7'd4, 32'h0000_0003, 32'h0, 32'h0, 32'h0, 1'b0);
    push_sample(7'd0, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0, 1'b0);
    wait_idle();

    // The new mode applies when the set is evaluated; no objective means every sample wins.
    set_register(REG_MODE, 1);
    push_sample(7'd2, 32'h7FFF_FFFF, 32'h1, 32'h2, 32'h3, 1'b1);
    wait_idle();

    // Single mode copies objective 3 alone.
    set_register(REG_MODE, 0);
    set_register(REG_MASK, 4'h8);
    push_sample(7'd1, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 32'h8000_0000, 1'b0);
    push_sample(7'd1, 32'h4444_4444, 32'h5555_5555, 32'h6666_6666, 32'h7FFF_FFFF, 1'b1);
    wait_idle();

    // Dominance on objectives 0 and 2 only.
    set_register(REG_MODE, 1);
    set_register(REG_MASK, 4'h5);
    push_sample(7'd1, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'h0, 1'b0);
    push_sample(7'd2, 32'h0000_0000, 32'h8000_0000, 32'h0001_0000, 32'h0, 1'b0);
    push_sample(7'd3, 32'h0001_0000, 32'h0, 32'h0000_0000, 32'h0, 1'b1);
    wait_idle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin set_register(REG_MODE, 1); set_register(REG_MASK, 4'hF); end
        1: begin set_register(REG_MODE, 0); set_register(REG_MASK, 4'hF); end
        2: begin set_register(REG_MODE, 1); set_register(REG_MASK, 4'h0); end
        3: begin set_register(REG_MODE, 0); set_register(REG_MASK, 4'h0); end
        default: begin
          set_register(REG_MODE, ph % 2 == 0);
          set_register(REG_MASK, $urandom_range(0, 15));
        end
      endcase
      n = 0;
      // One set per chosen phase fills the whole store, closed or not by its final bit.
      if (ph == 0 || ph == 5) begin
        push_random_set(N_SLOTS, $urandom_range(0, 1));
        n = N_SLOTS;
      end
      while (n < PHASE_ITEMS) begin
        r = $urandom_range(0, 19);
        if (r < 12) len = $urandom_range(1, 4);
        else if (r < 18) len = $urandom_range(5, 12);
        else len = $urandom_range(13, 40);
        push_random_set(len, 1'b1);
        n += len;
      end
      // Sometimes a partial set stays loaded across the next register change.
      if (ph != RAND_PHASES - 1 && $urandom_range(0, 2) == 0)
        push_random_set($urandom_range(1, 3), 1'b0);
      wait_idle();
    end

    if (fitness_expect_q.size() != 0) begin
      $error("%0d expected results never arrived", fitness_expect_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("pareto_dominance_fitness_unit regression: pass");
    end else begin
      $display("pareto_dominance_fitness_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("pareto_dominance_fitness_unit regression: fail");
    $finish;
  end

endmodule
